[rtl/core/mrf_pkg.sv]
// Shared types, constants and the CRC-16 byte update for the Modbus read request framer.
// No dependencies; every module in rtl/core imports this package.
`timescale 1ns / 1ps
`default_nettype none

package mrf_pkg;

  localparam int unsigned FRAME_LENGTH = 8;
  localparam int unsigned HEADER_BYTES = 6;
  localparam int unsigned POS_W        = $clog2(FRAME_LENGTH);
  localparam int unsigned NEED_W       = 18;
  localparam int unsigned QUEUE_DEPTH  = 2;
  localparam int unsigned QPTR_W       = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam logic [POS_W-1:0] POS_CRC_LO = POS_W'(HEADER_BYTES);
  localparam logic [POS_W-1:0] POS_LAST   = POS_W'(FRAME_LENGTH - 1);

  typedef enum logic [2:0] {
    REG_SLAVE_ADDRESS  = 3'd0,
    REG_COMMAND_CODE   = 3'd1,
    REG_START_ADDRESS  = 3'd2,
    REG_TRANSFER_COUNT = 3'd3,
    REG_ITEM_WIDTH     = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [7:0]  slave_address;
    logic [7:0]  command_code;
    logic [15:0] start_address;
    logic [7:0]  transfer_count;
    logic [3:0]  item_width;
  } cfg_t;

  // classified request handed from front to back
  typedef struct packed {
    logic room_error;
  } q_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef struct packed {
    logic busy;
    logic [POS_W-1:0] pos;
  } back_status_t;

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

[rtl/core/modbus_read_request_framer_core.sv]
// Top level of the Modbus RTU read request framer with CRC-16.
// Depends on mrf_pkg, mrf_cfg, mrf_front, mrf_queue and mrf_back.
`timescale 1ns / 1ps
`default_nettype none

// Each request item is checked against the buffer room (8 bytes, plus item_count
// times item_width for a write) and queued; a two-entry queue lets the input side
// keep accepting while a frame goes out. A short buffer gives one result item with
// room_error set. Otherwise eight items follow, one per cycle while the sink is
// ready: slave address, function code, start address high/low, 0x00, twice the
// transfer count, then the CRC-16 low and high bytes. The frame sequencer folds one
// header byte per cycle into the CRC while the sink is ready.
// Configuration writes are taken at any time and must come only while idle.
module modbus_read_request_framer_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output      logic        cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output      logic        in_ready_o,
  input  wire logic [15:0] buffer_room_i,
  input  wire logic        is_write_i,
  input  wire logic [12:0] item_count_i,
  output      logic        out_valid_o,
  input  wire logic        out_ready_i,
  output      logic [7:0]  frame_byte_o,
  output      logic        last_byte_o,
  output      logic        room_error_o
);
  import mrf_pkg::*;

  cfg_t         cfg;
  q_status_t    q_status;
  q_entry_t     push_entry, pop_entry;
  logic         push, pop;
  back_status_t back_status;

  mrf_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  mrf_front u_front (
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .buffer_room_i (buffer_room_i),
    .is_write_i    (is_write_i),
    .item_count_i  (item_count_i),
    .cfg_i         (cfg),
    .q_status_i    (q_status),
    .push_o        (push),
    .push_entry_o  (push_entry)
  );

  mrf_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .pop_i        (pop),
    .pop_entry_o  (pop_entry),
    .status_o     (q_status)
  );

  mrf_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .q_status_i   (q_status),
    .q_entry_i    (pop_entry),
    .pop_o        (pop),
    .status_o     (back_status),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .frame_byte_o (frame_byte_o),
    .last_byte_o  (last_byte_o),
    .room_error_o (room_error_o)
  );

  // an error item is always the only item of its request
  a_err_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && room_error_o) |-> last_byte_o)
    else $error("error item without last_byte");

  // while a frame is in flight the output never carries an error item
  a_busy_no_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (back_status.busy && out_valid_o) |-> !room_error_o)
    else $error("error item during frame");

  // a new request leaves the queue only between frames
  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> (!back_status.busy && !q_status.empty))
    else $error("queue popped during frame");

  // the final frame byte ends the frame walk
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (back_status.busy && back_status.pos == POS_LAST && (!out_valid_o || out_ready_i))
      |=> (!back_status.busy && out_valid_o && last_byte_o))
    else $error("frame did not end on last byte");

endmodule

`default_nettype wire

[rtl/core/mrf_cfg.sv]
// Configuration register file for the framer; write-only port, always ready.
// Depends on mrf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mrf_cfg (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         cfg_valid_i,
  output      logic         cfg_ready_o,
  input  wire logic [2:0]   cfg_index_i,
  input  wire logic [15:0]  cfg_data_i,
  output      mrf_pkg::cfg_t cfg_o
);
  import mrf_pkg::*;

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_SLAVE_ADDRESS:  cfg_d.slave_address  = cfg_data_i[7:0];
        REG_COMMAND_CODE:   cfg_d.command_code   = cfg_data_i[7:0];
        REG_START_ADDRESS:  cfg_d.start_address  = cfg_data_i;
        REG_TRANSFER_COUNT: cfg_d.transfer_count = cfg_data_i[7:0];
        REG_ITEM_WIDTH:     cfg_d.item_width     = cfg_data_i[3:0];
        default: ;  // unknown index: ignored
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.slave_address  <= 8'd1;
      cfg_q.command_code   <= 8'd3;
      cfg_q.start_address  <= 16'd0;
      cfg_q.transfer_count <= 8'd1;
      cfg_q.item_width     <= 4'd2;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

`default_nettype wire

[rtl/core/mrf_front.sv]
// Front end: accepts request items and classifies them by the buffer room check.
// Depends on mrf_pkg; pushes into mrf_queue.
`timescale 1ns / 1ps
`default_nettype none

module mrf_front (
  input  wire logic               in_valid_i,
  output      logic               in_ready_o,
  input  wire logic [15:0]        buffer_room_i,
  input  wire logic               is_write_i,
  input  wire logic [12:0]        item_count_i,
  input  wire mrf_pkg::cfg_t      cfg_i,
  input  wire mrf_pkg::q_status_t q_status_i,
  output      logic               push_o,
  output      mrf_pkg::q_entry_t  push_entry_o
);
  import mrf_pkg::*;

  logic [16:0]       payload;
  logic [NEED_W-1:0] need;

  assign payload = 17'(cfg_i.item_width) * 17'(item_count_i);
  assign need    = NEED_W'(FRAME_LENGTH) + (is_write_i ? NEED_W'(payload) : '0);

  assign in_ready_o              = !q_status_i.full;
  assign push_o                  = in_valid_i && in_ready_o;
  assign push_entry_o.room_error = NEED_W'(buffer_room_i) < need;

endmodule

`default_nettype wire

[rtl/core/mrf_queue.sv]
// Short FIFO of classified requests between the front end and the frame sequencer.
// Depends on mrf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mrf_queue (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire mrf_pkg::q_entry_t push_entry_i,
  input  wire logic              pop_i,
  output      mrf_pkg::q_entry_t pop_entry_o,
  output      mrf_pkg::q_status_t status_o
);
  import mrf_pkg::*;

  q_entry_t          mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] count_q;

  assign pop_entry_o    = mem_q[rd_ptr_q];
  assign status_o.full  = count_q == QCNT_W'(QUEUE_DEPTH);
  assign status_o.empty = count_q == '0;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      count_q <= count_q + QCNT_W'(push_i) - QCNT_W'(pop_i);
    end
  end

endmodule

`default_nettype wire

[rtl/core/mrf_back.sv]
// Back end: walks a frame a byte per cycle unless stalled, folds the header
// into the CRC, drives the registered result channel. Depends on mrf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mrf_back (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire mrf_pkg::cfg_t        cfg_i,
  input  wire mrf_pkg::q_status_t   q_status_i,
  input  wire mrf_pkg::q_entry_t    q_entry_i,
  output      logic                 pop_o,
  output      mrf_pkg::back_status_t status_o,
  output      logic                 out_valid_o,
  input  wire logic                 out_ready_i,
  output      logic [7:0]           frame_byte_o,
  output      logic                 last_byte_o,
  output      logic                 room_error_o
);
  import mrf_pkg::*;

  logic             busy_q, busy_d;
  logic [POS_W-1:0] pos_q, pos_d;
  logic [15:0]      crc_q, crc_d;
  logic             out_valid_q, out_valid_d;
  logic [7:0]       byte_q, byte_d;
  logic             last_q, last_d;
  logic             err_q, err_d;

  logic [7:0] hdr [HEADER_BYTES];
  logic       load_ok;
  logic [7:0] cur_byte;

  always_comb begin
    hdr[0] = cfg_i.slave_address;
    hdr[1] = cfg_i.command_code;
    hdr[2] = cfg_i.start_address[15:8];
    hdr[3] = cfg_i.start_address[7:0];
    hdr[4] = 8'h00;
    hdr[5] = {cfg_i.transfer_count[6:0], 1'b0};
  end

  // output slot is free or being emptied this cycle
  assign load_ok = !out_valid_q || out_ready_i;
  assign pop_o   = !busy_q && !q_status_i.empty && load_ok;

  always_comb begin
    if (pos_q < POS_CRC_LO) begin
      cur_byte = hdr[pos_q];
    end else if (pos_q == POS_CRC_LO) begin
      cur_byte = crc_q[7:0];
    end else begin
      cur_byte = crc_q[15:8];
    end
  end

  always_comb begin
    busy_d      = busy_q;
    pos_d       = pos_q;
    crc_d       = crc_q;
    out_valid_d = out_valid_q && !out_ready_i;
    byte_d      = byte_q;
    last_d      = last_q;
    err_d       = err_q;
    if (pop_o) begin
      out_valid_d = 1'b1;
      if (q_entry_i.room_error) begin
        byte_d = 8'h00;
        last_d = 1'b1;
        err_d  = 1'b1;
      end else begin
        byte_d = hdr[0];
        last_d = 1'b0;
        err_d  = 1'b0;
        crc_d  = crc16_byte(CRC_INIT, hdr[0]);
        pos_d  = POS_W'(1);
        busy_d = 1'b1;
      end
    end else if (busy_q && load_ok) begin
      out_valid_d = 1'b1;
      byte_d      = cur_byte;
      last_d      = pos_q == POS_LAST;
      err_d       = 1'b0;
      if (pos_q < POS_CRC_LO) begin
        crc_d = crc16_byte(crc_q, cur_byte);
      end
      if (pos_q == POS_LAST) begin
        busy_d = 1'b0;
        pos_d  = '0;
      end else begin
        pos_d = pos_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      pos_q       <= '0;
      crc_q       <= CRC_INIT;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      pos_q       <= pos_d;
      crc_q       <= crc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    last_q <= last_d;
    err_q  <= err_d;
  end

  assign status_o.busy = busy_q;
  assign status_o.pos  = pos_q;
  assign out_valid_o   = out_valid_q;
  assign frame_byte_o  = byte_q;
  assign last_byte_o   = last_q;
  assign room_error_o  = err_q;

endmodule

`default_nettype wire

[sim/tb.sv]
// Self-checking testbench for modbus_read_request_framer_core: directed table, then random
// requests over several register settings, each result checked against an in-bench predictor.
// Depends on mrf_pkg and the RTL under rtl/core.
`timescale 1ns / 1ps

module tb;
  import mrf_pkg::*;

  localparam int DIR_ROWS       = 33;
  localparam int DRAIN_CYCLES   = 16;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RAND_PHASES    = 9;
  localparam int PHASE_ITEMS    = 50;

  // indexes past the last register; writes there must change nothing
  localparam logic [2:0] REG_SPARE_LO = 3'd5;
  localparam logic [2:0] REG_SPARE_HI = 3'd7;

  // frame for the reset register values: 01 03 0000 0002, CRC C40B
  localparam logic [63:0] RESET_FRAME = 64'h0103_0000_0002_C40B;

  typedef enum logic [1:0] {
    ROW_CFG,
    ROW_PREDICT,
    ROW_SHORT,
    ROW_RESET_FRAME
  } row_kind_e;

  typedef struct packed {
    row_kind_e   kind;
    logic [15:0] word;
    logic        wr;
    logic [12:0] cnt;
    logic [2:0]  idx;
  } row_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       err;
  } reply_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic [15:0] buffer_room = '0;
  logic        is_write = 1'b0;
  logic [12:0] item_count = '0;
  row_kind_e   in_kind = ROW_PREDICT;
  logic        out_ready = 1'b0;

  logic        cfg_ready;
  logic        in_ready;
  logic        out_valid;
  logic [7:0]  frame_byte;
  logic        last_byte;
  logic        room_error;

  cfg_t   shadow;
  reply_t owed_bytes [$];
  row_t   script [DIR_ROWS];
  bit     src_burst;
  int     errors, requests, frames_seen, shorts_seen, cfg_writes, quiet_cycles;

  modbus_read_request_framer_core dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .buffer_room_i (buffer_room),
    .is_write_i    (is_write),
    .item_count_i  (item_count),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .frame_byte_o  (frame_byte),
    .last_byte_o   (last_byte),
    .room_error_o  (room_error)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic void owe(input logic [7:0] data, input logic last, input logic err);
    reply_t r;
    r.data = data;
    r.last = last;
    r.err  = err;
    owed_bytes.push_back(r);
  endfunction

  function automatic logic [15:0] header_crc(input logic [47:0] header);
    logic [15:0] crc;
    logic        lsb;
    crc = CRC_INIT;
    for (int b = 0; b < HEADER_BYTES; b++) begin
      crc[7:0] = crc[7:0] ^ header[47 - 8*b -: 8];
      for (int k = 0; k < 8; k++) begin
        lsb = crc[0];
        crc = crc >> 1;
        if (lsb) crc = crc ^ CRC_POLY;
      end
    end
    return crc;
  endfunction

  // expected reply items for one request under the current register values
  function automatic void frame_response(input logic [15:0] room, input logic wr,
                                         input logic [12:0] cnt);
    logic [17:0] need;
    logic [47:0] header;
    logic [15:0] crc;
    need = 18'(FRAME_LENGTH);
    if (wr) need = need + 18'(shadow.item_width) * 18'(cnt);
    if (18'(room) < need) begin
      owe(8'h00, 1'b1, 1'b1);
    end else begin
      header = {shadow.slave_address, shadow.command_code, shadow.start_address, 8'h00,
                shadow.transfer_count[6:0], 1'b0};
      crc = header_crc(header);
      for (int i = 0; i < HEADER_BYTES; i++) owe(header[47 - 8*i -: 8], 1'b0, 1'b0);
      owe(crc[7:0], 1'b0, 1'b0);
      owe(crc[15:8], 1'b1, 1'b0);
    end
  endfunction

  function automatic void apply_write(input logic [2:0] idx, input logic [15:0] data);
    case (idx)
      REG_SLAVE_ADDRESS:  shadow.slave_address  = data[7:0];
      REG_COMMAND_CODE:   shadow.command_code   = data[7:0];
      REG_START_ADDRESS:  shadow.start_address  = data;
      REG_TRANSFER_COUNT: shadow.transfer_count = data[7:0];
      REG_ITEM_WIDTH:     shadow.item_width     = data[3:0];
      default: ;
    endcase
  endfunction

  // input and config acceptance first, so a same-edge result still finds its expectation
  always @(posedge clk) begin
    reply_t want;
    if (rst_n && in_valid && in_ready) begin
      requests++;
      case (in_kind)
        ROW_SHORT: owe(8'h00, 1'b1, 1'b1);
        ROW_RESET_FRAME: begin
          for (int i = 0; i < FRAME_LENGTH; i++)
            owe(RESET_FRAME[63 - 8*i -: 8], i == FRAME_LENGTH - 1, 1'b0);
        end
        default: frame_response(buffer_room, is_write, item_count);
      endcase
    end
    if (rst_n && cfg_valid && cfg_ready) begin
      cfg_writes++;
      apply_write(cfg_index, cfg_data);
    end
    if (rst_n && out_valid && out_ready) begin
      if (owed_bytes.size() == 0) begin
        $error("result item with nothing outstanding: frame_byte %0h", frame_byte);
        errors++;
      end else begin
        want = owed_bytes.pop_front();
        if (frame_byte !== want.data) begin
          $error("frame_byte: expected %0h, got %0h", want.data, frame_byte);
          errors++;
        end
        if (last_byte !== want.last) begin
          $error("last_byte: expected %0b, got %0b", want.last, last_byte);
          errors++;
        end
        if (room_error !== want.err) begin
          $error("room_error: expected %0b, got %0b", want.err, room_error);
          errors++;
        end
        if (want.last && want.err) shorts_seen++;
        else if (want.last) frames_seen++;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (rst_n) begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("timeout: no item moved for %0d cycles", WATCHDOG_LIMIT);
      $display("FAIL");
      $finish;
    end
  end

  // result sink with random stalls, plus stretches of none
  initial begin
    int stall;
    bit sink_burst;
    sink_burst = 1'b0;
    wait (rst_n);
    forever begin
      if ($urandom_range(0, 59) == 0) sink_burst = !sink_burst;
      stall = sink_burst ? 0 : $urandom_range(0, 14);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic send_request(input logic [15:0] room, input logic wr, input logic [12:0] cnt,
                              input row_kind_e kind);
    int gap;
    gap = src_burst ? 0 : $urandom_range(0, 14);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    buffer_room <= room;
    is_write    <= wr;
    item_count  <= cnt;
    in_kind     <= kind;
    do @(posedge clk); while (!in_ready);
  endtask

  // caller lowers cfg_valid after the last write of a series
  task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (owed_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // new register values, extremes about half the time; unused bits carry noise
  task automatic retune();
    logic [15:0] mask;
    logic [15:0] data;
    for (int i = REG_SLAVE_ADDRESS; i <= REG_ITEM_WIDTH; i++) begin
      if ($urandom_range(0, 3) != 0) begin
        case (3'(i))
          REG_START_ADDRESS: mask = 16'hFFFF;
          REG_ITEM_WIDTH:    mask = 16'h000F;
          default:           mask = 16'h00FF;
        endcase
        data = 16'($urandom);
        case ($urandom_range(0, 3))
          0: data = data & ~mask;
          1: data = data | mask;
          default: ;
        endcase
        write_reg(3'(i), data);
      end
    end
    if ($urandom_range(0, 3) == 0)
      write_reg(REG_SPARE_LO + 3'($urandom_range(0, REG_SPARE_HI - REG_SPARE_LO)),
                16'($urandom));
    cfg_valid <= 1'b0;
  endtask

  // mostly requests that fit, a good share right at the room boundary
  task automatic random_request();
    logic        wr;
    logic [12:0] cnt;
    logic [15:0] room;
    int          need;
    int          sel;
    wr  = 1'($urandom_range(0, 1));
    cnt = ($urandom_range(0, 3) == 0) ? 13'($urandom) : 13'($urandom_range(0, 40));
    need = FRAME_LENGTH + (wr ? int'(shadow.item_width) * int'(cnt) : 0);
    sel = $urandom_range(0, 9);
    if (sel < 2 || need > 65535) begin
      room = 16'($urandom);
    end else if (sel < 5) begin
      need = need + $urandom_range(0, 2) - 1;
      room = (need > 65535) ? 16'hFFFF : 16'(need);
    end else begin
      need = need + $urandom_range(0, 300);
      room = (need > 65535) ? 16'hFFFF : 16'(need);
    end
    send_request(room, wr, cnt, ROW_PREDICT);
  endtask

  initial begin
    bit cfg_open;
    shadow.slave_address  = 8'd1;
    shadow.command_code   = 8'd3;
    shadow.start_address  = 16'd0;
    shadow.transfer_count = 8'd1;
    shadow.item_width     = 4'd2;
    script = '{
      '{ROW_RESET_FRAME, 16'd8,     1'b0, 13'd0,    3'd0},
      '{ROW_SHORT,       16'd7,     1'b0, 13'd0,    3'd0},
      '{ROW_SHORT,       16'd0,     1'b1, 13'd0,    3'd0},
      '{ROW_RESET_FRAME, 16'hFFFF,  1'b0, 13'h1FFF, 3'd0},
      '{ROW_PREDICT,     16'hFFFF,  1'b1, 13'h1FFF, 3'd0},
      '{ROW_SHORT,       16'd9,     1'b1, 13'd1,    3'd0},
      '{ROW_PREDICT,     16'd10,    1'b1, 13'd1,    3'd0},
      '{ROW_CFG,         16'hA5FF,  1'b0, 13'd0,    REG_SLAVE_ADDRESS},
      '{ROW_CFG,         16'h5AFF,  1'b0, 13'd0,    REG_COMMAND_CODE},
      '{ROW_CFG,         16'hFFFF,  1'b0, 13'd0,    REG_START_ADDRESS},
      '{ROW_CFG,         16'h00FF,  1'b0, 13'd0,    REG_TRANSFER_COUNT},
      '{ROW_CFG,         16'hFFFF,  1'b0, 13'd0,    REG_ITEM_WIDTH},
      '{ROW_CFG,         16'h0000,  1'b0, 13'd0,    REG_SPARE_LO},
      // width 15: widest payload check, one byte short, then exact fit
      '{ROW_SHORT,       16'hFFFF,  1'b1, 13'h1FFF, 3'd0},
      '{ROW_SHORT,       16'd65527, 1'b1, 13'd4368, 3'd0},
      '{ROW_PREDICT,     16'd65528, 1'b1, 13'd4368, 3'd0},
      '{ROW_PREDICT,     16'd8,     1'b0, 13'h1FFF, 3'd0},
      '{ROW_CFG,         16'hFF00,  1'b0, 13'd0,    REG_SLAVE_ADDRESS},
      '{ROW_CFG,         16'hFF00,  1'b0, 13'd0,    REG_COMMAND_CODE},
      '{ROW_CFG,         16'h0000,  1'b0, 13'd0,    REG_START_ADDRESS},
      '{ROW_CFG,         16'hFF00,  1'b0, 13'd0,    REG_TRANSFER_COUNT},
      '{ROW_CFG,         16'hFFF0,  1'b0, 13'd0,    REG_ITEM_WIDTH},
      '{ROW_CFG,         16'hFFFF,  1'b0, 13'd0,    REG_SPARE_HI},
      '{ROW_PREDICT,     16'd8,     1'b1, 13'h1FFF, 3'd0},
      '{ROW_SHORT,       16'd7,     1'b1, 13'd0,    3'd0},
      '{ROW_CFG,         16'h0080,  1'b0, 13'd0,    REG_TRANSFER_COUNT},
      '{ROW_CFG,         16'h8001,  1'b0, 13'd0,    REG_START_ADDRESS},
      '{ROW_CFG,         16'h0008,  1'b0, 13'd0,    REG_ITEM_WIDTH},
      '{ROW_CFG,         16'h0080,  1'b0, 13'd0,    REG_SLAVE_ADDRESS},
      '{ROW_PREDICT,     16'd8,     1'b0, 13'd0,    3'd0},
      '{ROW_PREDICT,     16'd23,    1'b1, 13'd2,    3'd0},
      '{ROW_PREDICT,     16'd24,    1'b1, 13'd2,    3'd0},
      '{ROW_PREDICT,     16'h8000,  1'b1, 13'h0AAA, 3'd0}
    };
    cfg_open  = 1'b0;
    src_burst = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int r = 0; r < DIR_ROWS; r++) begin
      if (script[r].kind == ROW_CFG) begin
        if (!cfg_open) begin
          settle();
          cfg_open = 1'b1;
        end
        write_reg(script[r].idx, script[r].word);
      end else begin
        if (cfg_open) begin
          cfg_valid <= 1'b0;
          cfg_open = 1'b0;
        end
        send_request(script[r].word, script[r].wr, script[r].cnt, script[r].kind);
      end
    end

    for (int p = 0; p < RAND_PHASES; p++) begin
      settle();
      retune();
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if ($urandom_range(0, 39) == 0) src_burst = !src_burst;
        random_request();
      end
    end
    settle();

    $display("covered %0d requests over %0d register writes", requests, cfg_writes);
    $display("replies: %0d full frames, %0d short-buffer errors", frames_seen, shorts_seen);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
